// File: rtl/core/pfi_pkg.sv
// pfi_pkg: types, constants and arithmetic helpers for the particle force integrator
`default_nettype none

package pfi_pkg;

    localparam int QW = 32;
    localparam int DIV_STEPS = 33;
    localparam logic signed [QW-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_GRAVITY_X = 3'd1,
        REG_GRAVITY_Y = 3'd2,
        REG_TIME_STEP = 3'd3,
        REG_DENSITY   = 3'd4,
        REG_WIND_X    = 3'd5,
        REG_WIND_Y    = 3'd6
    } t_reg_idx;

    // integrator selection
    typedef enum logic [1:0] {
        MODE_VERLET     = 2'd0,
        MODE_SYMPLECTIC = 2'd1,
        MODE_POS_FIRST  = 2'd2,
        MODE_HOLD       = 2'd3
    } t_mode;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [30:0]        body_mass;
        logic [30:0]        surface_area;
        logic [30:0]        drag_coef;
        logic [30:0]        lift_coef;
        logic [30:0]        limit_x;
        logic [30:0]        limit_y;
        logic               in_water;
    } t_req;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
    } t_res;

    // one lane of the restoring divider
    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic        zero;
        logic [30:0] rem;
        logic [32:0] num;
        logic [32:0] quo;
    } t_div;

    // everything an item carries down the pipeline
    typedef struct packed {
        t_req               req;
        logic signed [31:0] fgx;
        logic signed [31:0] fgy;
        logic signed [31:0] dvx;
        logic signed [31:0] dvy;
        logic [63:0]        sqx;
        logic [63:0]        sqy;
        logic [30:0]        sp;
        logic signed [31:0] aero;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        t_div               divx;
        t_div               divy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] qax;
        logic signed [31:0] qay;
        logic signed [31:0] qvx;
        logic signed [31:0] qvy;
        logic signed [31:0] qaax;
        logic signed [31:0] qaay;
        logic signed [31:0] nvx;
        logic signed [31:0] nvy;
        logic signed [31:0] qnvx;
        logic signed [31:0] qnvy;
        logic signed [33:0] spx;
        logic signed [33:0] spy;
    } t_pipe;

    // saturate to the signed Q16.16 range
    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        logic signed [31:0] r;
        if (x > 50'(Q_MAX)) begin
            r = Q_MAX;
        end else if (x < 50'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Q16.16 multiply, floor rounding, saturated
    function automatic logic signed [31:0] qmul(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        p = a * b;
        return sat32(50'(p >>> 16));
    endfunction

    // one quotient bit of the restoring divider
    function automatic t_div div_step(input t_div d, input logic [30:0] m);
        t_div        r;
        logic [31:0] shifted;
        logic        qbit;
        r       = d;
        shifted = {d.rem, d.num[32]};
        qbit    = (shifted >= {1'b0, m});
        if (qbit) begin
            shifted = shifted - {1'b0, m};
        end
        r.rem = shifted[30:0];
        r.num = {d.num[31:0], 1'b0};
        r.quo = {d.quo[31:0], qbit};
        return r;
    endfunction

    // prepare a divider lane from a force value
    function automatic t_div div_init(input logic signed [31:0] f, input logic [30:0] m);
        t_div        r;
        logic [31:0] mag;
        mag    = f[31] ? 32'(-33'(f)) : 32'(f);
        r.neg  = f[31];
        r.zero = (mag == '0);
        r.ovf  = ({16'b0, mag[31:17]} >= m);
        r.rem  = {16'b0, mag[31:17]};
        r.num  = {mag[16:0], 16'b0};
        r.quo  = '0;
        return r;
    endfunction

    // final acceleration from a finished divider lane
    function automatic logic signed [31:0] div_result(input t_div d);
        logic signed [31:0] r;
        if (d.ovf) begin
            r = d.zero ? '0 : (d.neg ? Q_MIN : Q_MAX);
        end else if (d.neg) begin
            r = sat32(-50'($signed({1'b0, d.quo})));
        end else begin
            r = sat32(50'($signed({1'b0, d.quo})));
        end
        return r;
    endfunction

    // clamp a velocity to plus or minus a limit
    function automatic logic signed [31:0] clampv(input logic signed [31:0] v,
                                                  input logic [30:0] lim);
        logic signed [32:0] l;
        logic signed [31:0] r;
        l = $signed({2'b0, lim});
        if (33'(v) > l) begin
            r = 32'(l);
        end else if (33'(v) < -l) begin
            r = 32'(-l);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/particle_force_integrator.sv
// particle_force_integrator: pipelined drag, acceleration and integration step
`default_nettype none

// One body is taken in every clock cycle and never refused: o_busy stays low.
// Each request gives exactly one result, in request order. o_done is high for
// one cycle per request, with the result on o_res. Each request passes through
// the 8 force stages, then the 33-stage restoring divider that forms force /
// mass, then the 5 integration and output stages. The receiver cannot stall
// the pipeline. Configuration may be written only while no request is in
// flight.
module particle_force_integrator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    input  wire pfi_pkg::t_req i_req,
    output logic               o_done,
    output pfi_pkg::t_res      o_res,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data
);
    import pfi_pkg::*;

    localparam int NPRE = 8;
    localparam int NPOST = 5;

    // configuration registers
    t_mode              r_mode;
    logic signed [31:0] r_gx;
    logic signed [31:0] r_gy;
    logic [15:0]        r_dt;
    logic [30:0]        r_dens;
    logic signed [31:0] r_wx;
    logic signed [31:0] r_wy;

    logic signed [32:0] dt_s;
    assign dt_s = $signed({17'b0, r_dt});

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_VERLET;
            r_gx   <= '0;
            r_gy   <= '0;
            r_dt   <= 16'd1092;
            r_dens <= '0;
            r_wx   <= '0;
            r_wy   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_MODE:      r_mode <= t_mode'(i_cfg_data[1:0]);
                REG_GRAVITY_X: r_gx   <= i_cfg_data;
                REG_GRAVITY_Y: r_gy   <= i_cfg_data;
                REG_TIME_STEP: r_dt   <= i_cfg_data[15:0];
                REG_DENSITY:   r_dens <= i_cfg_data[30:0];
                REG_WIND_X:    r_wx   <= i_cfg_data;
                REG_WIND_Y:    r_wy   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // valid bits for every stage
    logic [NPRE-1:0]      r_vpre;
    logic [DIV_STEPS-1:0] r_vdiv;
    logic [NPOST-1:0]     r_vpost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpre  <= '0;
            r_vdiv  <= '0;
            r_vpost <= '0;
        end else begin
            r_vpre  <= {r_vpre[NPRE-2:0], i_start};
            r_vdiv  <= {r_vdiv[DIV_STEPS-2:0], r_vpre[NPRE-1]};
            r_vpost <= {r_vpost[NPOST-2:0], r_vdiv[DIV_STEPS-1]};
        end
    end
    assign o_done = r_vpost[NPOST-1];

    t_pipe r_pre  [NPRE];
    t_pipe r_div  [DIV_STEPS];
    t_pipe r_post [NPOST-1];
    t_pipe n_s0;

    // stage 0: relative wind speed and weight
    always_comb begin
        n_s0     = '0;
        n_s0.req = i_req;
        n_s0.dvx = sat32(50'(i_req.vel_x) - 50'(r_wx));
        n_s0.dvy = sat32(50'(i_req.vel_y) - 50'(r_wy));
        n_s0.fgx = qmul($signed({2'b0, i_req.body_mass}), 33'(r_gx));
        n_s0.fgy = qmul($signed({2'b0, i_req.body_mass}), 33'(r_gy));
    end

    // force pipeline ahead of the divider
    always_ff @(posedge i_clk) begin
        logic [31:0] ux;
        logic [31:0] uy;
        logic [64:0] sum;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        t_pipe t;
        r_pre[0] <= n_s0;

        // squares of the relative speed
        ux = r_pre[0].dvx[31] ? 32'(-33'(r_pre[0].dvx)) : 32'(r_pre[0].dvx);
        uy = r_pre[0].dvy[31] ? 32'(-33'(r_pre[0].dvy)) : 32'(r_pre[0].dvy);
        t     = r_pre[0];
        t.sqx = ux * ux;
        t.sqy = uy * uy;
        r_pre[1] <= t;

        // squared speed in Q16.16
        sum  = 65'(r_pre[1].sqx) + 65'(r_pre[1].sqy);
        t    = r_pre[1];
        t.sp = (sum[64:16] > 49'h7fff_ffff) ? 31'h7fff_ffff : sum[46:16];
        r_pre[2] <= t;

        // density times squared speed
        t      = r_pre[2];
        t.aero = qmul($signed({2'b0, r_dens}), $signed({2'b0, r_pre[2].sp}));
        r_pre[3] <= t;

        // times surface
        t      = r_pre[3];
        t.aero = qmul(33'(r_pre[3].aero), $signed({2'b0, r_pre[3].req.surface_area}));
        r_pre[4] <= t;

        // times drag and lift coefficients
        t    = r_pre[4];
        t.dx = qmul(33'(r_pre[4].aero), $signed({2'b0, r_pre[4].req.drag_coef}));
        t.dy = qmul(33'(r_pre[4].aero), $signed({2'b0, r_pre[4].req.lift_coef}));
        r_pre[5] <= t;

        // net force, drag and lift only for a moving body out of water
        fx = r_pre[5].fgx;
        fy = r_pre[5].fgy;
        if (r_pre[5].req.vel_x != '0 && !r_pre[5].req.in_water) begin
            fx = sat32(50'(r_pre[5].fgx) - 50'(r_pre[5].dx >>> 1));
        end
        if (r_pre[5].req.vel_y != '0 && !r_pre[5].req.in_water) begin
            fy = sat32(50'(r_pre[5].fgy) - 50'(r_pre[5].dy >>> 1));
        end
        t    = r_pre[5];
        t.fx = fx;
        t.fy = fy;
        r_pre[6] <= t;

        // divider setup
        t      = r_pre[6];
        t.divx = div_init(r_pre[6].fx, r_pre[6].req.body_mass);
        t.divy = div_init(r_pre[6].fy, r_pre[6].req.body_mass);
        r_pre[7] <= t;
    end

    // restoring divider, one quotient bit per stage
    always_ff @(posedge i_clk) begin
        t_pipe t;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                t = r_pre[NPRE-1];
            end else begin
                t = r_div[k-1];
            end
            t.divx = div_step(t.divx, t.req.body_mass);
            t.divy = div_step(t.divy, t.req.body_mass);
            r_div[k] <= t;
        end
    end

    // integration stages
    always_ff @(posedge i_clk) begin
        t_pipe t;
        // acceleration
        t    = r_div[DIV_STEPS-1];
        t.ax = div_result(r_div[DIV_STEPS-1].divx);
        t.ay = div_result(r_div[DIV_STEPS-1].divy);
        r_post[0] <= t;

        // a*dt and v*dt
        t     = r_post[0];
        t.qax = qmul(33'(r_post[0].ax), dt_s);
        t.qay = qmul(33'(r_post[0].ay), dt_s);
        t.qvx = qmul(33'(r_post[0].req.vel_x), dt_s);
        t.qvy = qmul(33'(r_post[0].req.vel_y), dt_s);
        r_post[1] <= t;

        // a*dt*dt and new velocity
        t      = r_post[1];
        t.qaax = qmul(33'(r_post[1].qax), dt_s);
        t.qaay = qmul(33'(r_post[1].qay), dt_s);
        t.nvx  = sat32(50'(r_post[1].req.vel_x) + 50'(r_post[1].qax));
        t.nvy  = sat32(50'(r_post[1].req.vel_y) + 50'(r_post[1].qay));
        r_post[2] <= t;

        // new velocity times dt and the Verlet position sum
        t      = r_post[2];
        t.qnvx = qmul(33'(r_post[2].nvx), dt_s);
        t.qnvy = qmul(33'(r_post[2].nvy), dt_s);
        t.spx  = 34'(r_post[2].req.pos_x) + 34'(r_post[2].qvx)
               + 34'(r_post[2].qaax >>> 1);
        t.spy  = 34'(r_post[2].req.pos_y) + 34'(r_post[2].qvy)
               + 34'(r_post[2].qaay >>> 1);
        r_post[3] <= t;
    end

    // result selection, and velocity clamp in every mode but hold
    t_pipe p;
    assign p = r_post[3];

    always_ff @(posedge i_clk) begin
        unique case (r_mode)
            MODE_VERLET: begin
                o_res.new_pos_x <= sat32(50'(p.spx));
                o_res.new_pos_y <= sat32(50'(p.spy));
                o_res.new_vel_x <= clampv(p.nvx, p.req.limit_x);
                o_res.new_vel_y <= clampv(p.nvy, p.req.limit_y);
            end
            MODE_SYMPLECTIC: begin
                o_res.new_pos_x <= sat32(50'(p.req.pos_x) + 50'(p.qnvx));
                o_res.new_pos_y <= sat32(50'(p.req.pos_y) + 50'(p.qnvy));
                o_res.new_vel_x <= clampv(p.nvx, p.req.limit_x);
                o_res.new_vel_y <= clampv(p.nvy, p.req.limit_y);
            end
            MODE_POS_FIRST: begin
                o_res.new_pos_x <= sat32(50'(p.req.pos_x) + 50'(p.qvx));
                o_res.new_pos_y <= sat32(50'(p.req.pos_y) + 50'(p.qvy));
                o_res.new_vel_x <= clampv(p.nvx, p.req.limit_x);
                o_res.new_vel_y <= clampv(p.nvy, p.req.limit_y);
            end
            MODE_HOLD: begin
                o_res.new_pos_x <= p.req.pos_x;
                o_res.new_pos_y <= p.req.pos_y;
                o_res.new_vel_x <= p.req.vel_x;
                o_res.new_vel_y <= p.req.vel_y;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
